// ----- rtl/core/amu_pkg.sv -----
package amu_pkg;

    localparam int ADDR_BITS = 16;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [7:0]           byte_t;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_PUSH  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [3:0] MODE_NONE     = 4'd0;
    localparam logic [3:0] MODE_DP       = 4'd1;
    localparam logic [3:0] MODE_DP_X     = 4'd2;
    localparam logic [3:0] MODE_DP_Y     = 4'd3;
    localparam logic [3:0] MODE_DP_IND   = 4'd4;
    localparam logic [3:0] MODE_ABS      = 4'd5;
    localparam logic [3:0] MODE_X_IND    = 4'd6;
    localparam logic [3:0] MODE_ABS_X    = 4'd7;
    localparam logic [3:0] MODE_ABS_Y    = 4'd8;
    localparam logic [3:0] MODE_DPX_IND  = 4'd9;
    localparam logic [3:0] MODE_DPIND_Y  = 4'd10;
    localparam logic [3:0] MODE_ABSX_IND = 4'd11;
    localparam logic [3:0] MODE_Y_IND    = 4'd12;

    localparam addr_t PORT_FIRST   = 16'h00F4;
    localparam addr_t PORT_LAST    = 16'h00F7;
    localparam addr_t PROTECT_BASE = 16'hFFC0;
    localparam addr_t PAGE_ONE     = 16'h0100;

    typedef struct packed {
        logic  en;
        logic  we;
        addr_t addr;
        byte_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic  indirect;
        logic  add_y;
        addr_t addr;
    } agen_t;

endpackage

// ----- rtl/core/amu_ram.sv -----
module amu_ram (
    input  logic              clk,
    input  amu_pkg::mem_req_t req,
    output amu_pkg::byte_t    rdata
);
    import amu_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    byte_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

// ----- rtl/core/amu_agen.sv -----
module amu_agen (
    input  logic           [3:0] mode,
    input  amu_pkg::addr_t       operand,
    input  amu_pkg::byte_t       x,
    input  amu_pkg::byte_t       y,
    input  logic                 page,
    output amu_pkg::agen_t       gen
);
    import amu_pkg::*;

    byte_t page_hi;
    byte_t dp_x;
    byte_t dp_y;
    addr_t abs_x;
    addr_t abs_y;

    assign page_hi = page ? PAGE_ONE[15:8] : 8'h00;
    assign dp_x    = operand[7:0] + x;
    assign dp_y    = operand[7:0] + y;
    assign abs_x   = operand + {8'h00, x};
    assign abs_y   = operand + {8'h00, y};

    always_comb
    begin
        gen = '{indirect: 1'b0, add_y: 1'b0, addr: operand};
        case (mode)
            MODE_DP:       gen.addr = {page_hi, operand[7:0]};
            MODE_DP_X:     gen.addr = {page_hi, dp_x};
            MODE_DP_Y:     gen.addr = {page_hi, dp_y};
            MODE_DP_IND:
            begin
                gen.indirect = 1'b1;
                gen.addr     = {page_hi, operand[7:0]};
            end
            MODE_ABS:      gen.addr = operand;
            MODE_X_IND:    gen.addr = {page_hi, x};
            MODE_ABS_X:    gen.addr = abs_x;
            MODE_ABS_Y:    gen.addr = abs_y;
            MODE_DPX_IND:
            begin
                gen.indirect = 1'b1;
                gen.addr     = {page_hi, dp_x};
            end
            MODE_DPIND_Y:
            begin
                gen.indirect = 1'b1;
                gen.add_y    = 1'b1;
                gen.addr     = {page_hi, operand[7:0]};
            end
            MODE_ABSX_IND:
            begin
                gen.indirect = 1'b1;
                gen.addr     = abs_x;
            end
            MODE_Y_IND:    gen.addr = {page_hi, y};
            default:       gen.addr = operand;
        endcase
    end

endmodule

// ----- rtl/core/addressing_mode_memory_unit_top.sv -----
// Memory front end with a 64 KiB single-port byte RAM and four mapped ports.
// Issue an item by raising start while busy is low; all item fields are
// sampled at that edge. busy stays high while the item walks the RAM.
// The result appears on read_data, effective_address, stack_pointer_out,
// port_write_mask and port_write_data for exactly one cycle, marked by done.
// The receiver cannot stall; results must be taken in the done cycle.
// States an item passes through after the accepting edge, up to done:
//   unused operation                   S_CAPT
//   byte access, push, pop, raw load   S_ACC0, S_CAPT
//   word access                        S_ACC0, S_ACC1, S_CAPT
//   indirect modes first add S_PTR0 and S_PTR1 for the two pointer byte reads
// A new item may be started in the done cycle; indirect word accesses hold
// the single RAM port longest.
// Reset clears the registers only; RAM content is undefined until
// written and needs no clearing pass.
module addressing_mode_memory_unit_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic           [2:0] operation,
    input  logic           [3:0] address_mode,
    input  logic                 access_word,
    input  amu_pkg::addr_t       operand_address,
    input  logic          [15:0] write_value,
    input  amu_pkg::byte_t       index_x,
    input  amu_pkg::byte_t       index_y,
    input  logic                 page_one_select,
    input  amu_pkg::byte_t       stack_pointer_in,
    input  logic          [31:0] port_values,
    output logic                 done,
    output logic          [15:0] read_data,
    output amu_pkg::addr_t       effective_address,
    output amu_pkg::byte_t       stack_pointer_out,
    output logic           [3:0] port_write_mask,
    output logic          [31:0] port_write_data
);
    import amu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR0,
        S_PTR1,
        S_ACC0,
        S_ACC1,
        S_CAPT
    } state_t;

    state_t      state_reg;
    logic        done_reg;
    logic        read_reg;
    logic        write_reg;
    logic        raw_reg;
    logic        word_reg;
    logic        ind_reg;
    logic        addy_reg;
    addr_t       ptr_reg;
    addr_t       ea_reg;
    byte_t       ptr_lo_reg;
    byte_t       y_reg;
    byte_t       sp_reg;
    logic [15:0] val_reg;
    logic [31:0] port_in_reg;
    byte_t       lo_reg;
    byte_t       hi_reg;
    logic        lo_ram_reg;
    logic        hi_ram_reg;
    logic [15:0] rd_reg;
    logic [3:0]  mask_reg;
    logic [31:0] pdata_reg;

    agen_t       gen;
    mem_req_t    mem_req;
    byte_t       mem_rdata;
    addr_t       ea_ind;
    addr_t       acc_addr;
    addr_t       acc_off;
    byte_t       acc_byte;
    logic        acc_port;
    logic        acc_prot;
    logic [1:0]  acc_lane;
    logic [31:0] port_shift;
    byte_t       port_byte;
    byte_t       sp_dec;
    byte_t       sp_inc;

    amu_agen u_agen (
        .mode    (address_mode),
        .operand (operand_address),
        .x       (index_x),
        .y       (index_y),
        .page    (page_one_select),
        .gen     (gen)
    );

    amu_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign sp_dec = stack_pointer_in - 8'd1;
    assign sp_inc = stack_pointer_in + 8'd1;

    assign ea_ind   = {mem_rdata, ptr_lo_reg} + (addy_reg ? {8'h00, y_reg} : 16'h0000);
    assign acc_addr = (state_reg == S_ACC1) ? ea_reg + 16'd1 :
                      (ind_reg ? ea_ind : ea_reg);
    assign acc_byte = (state_reg == S_ACC1) ? val_reg[15:8] : val_reg[7:0];
    assign acc_port = (acc_addr >= PORT_FIRST) && (acc_addr <= PORT_LAST);
    assign acc_prot = acc_addr >= PROTECT_BASE;
    assign acc_off  = acc_addr - PORT_FIRST;
    assign acc_lane = acc_off[1:0];
    assign port_shift = port_in_reg >> {acc_lane, 3'b000};
    assign port_byte  = port_shift[7:0];

    always_comb
    begin
        mem_req = '{en: 1'b0, we: 1'b0, addr: acc_addr, wdata: acc_byte};
        case (state_reg)
            S_PTR0:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = ptr_reg;
            end
            S_PTR1:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = ptr_reg + 16'd1;
            end
            S_ACC0, S_ACC1:
            begin
                if (read_reg && !acc_port)
                begin
                    mem_req.en = 1'b1;
                end
                if (write_reg && (raw_reg || (!acc_port && !acc_prot)))
                begin
                    mem_req.en = 1'b1;
                    mem_req.we = 1'b1;
                end
            end
            default:
            begin
                mem_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            read_reg    <= 1'b0;
            write_reg   <= 1'b0;
            raw_reg     <= 1'b0;
            word_reg    <= 1'b0;
            ind_reg     <= 1'b0;
            addy_reg    <= 1'b0;
            ptr_reg     <= '0;
            ea_reg      <= '0;
            ptr_lo_reg  <= '0;
            y_reg       <= '0;
            sp_reg      <= '0;
            val_reg     <= '0;
            port_in_reg <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            lo_ram_reg  <= 1'b0;
            hi_ram_reg  <= 1'b0;
            rd_reg      <= '0;
            mask_reg    <= '0;
            pdata_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        val_reg     <= write_value;
                        y_reg       <= index_y;
                        port_in_reg <= port_values;
                        sp_reg      <= stack_pointer_in;
                        mask_reg    <= '0;
                        pdata_reg   <= '0;
                        read_reg    <= 1'b0;
                        write_reg   <= 1'b0;
                        raw_reg     <= 1'b0;
                        word_reg    <= 1'b0;
                        ind_reg     <= 1'b0;
                        addy_reg    <= 1'b0;
                        ea_reg      <= '0;
                        state_reg   <= S_ACC0;
                        case (operation)
                            OP_READ, OP_WRITE:
                            begin
                                read_reg  <= (operation == OP_READ);
                                write_reg <= (operation == OP_WRITE);
                                word_reg  <= access_word;
                                ind_reg   <= gen.indirect;
                                addy_reg  <= gen.add_y;
                                ptr_reg   <= gen.addr;
                                ea_reg    <= gen.addr;
                                if (gen.indirect)
                                begin
                                    state_reg <= S_PTR0;
                                end
                            end
                            OP_PUSH:
                            begin
                                write_reg <= 1'b1;
                                ea_reg    <= PAGE_ONE | {8'h00, stack_pointer_in};
                                sp_reg    <= sp_dec;
                            end
                            OP_POP:
                            begin
                                read_reg <= 1'b1;
                                ea_reg   <= PAGE_ONE | {8'h00, sp_inc};
                                sp_reg   <= sp_inc;
                            end
                            OP_LOAD:
                            begin
                                write_reg <= 1'b1;
                                raw_reg   <= 1'b1;
                                ea_reg    <= operand_address;
                            end
                            default:
                            begin
                                state_reg <= S_CAPT;
                            end
                        endcase
                    end
                end
                S_PTR0:
                begin
                    state_reg <= S_PTR1;
                end
                S_PTR1:
                begin
                    ptr_lo_reg <= mem_rdata;
                    state_reg  <= S_ACC0;
                end
                S_ACC0:
                begin
                    ea_reg     <= acc_addr;
                    ind_reg    <= 1'b0;
                    lo_ram_reg <= !acc_port;
                    lo_reg     <= port_byte;
                    if (write_reg && !raw_reg && acc_port)
                    begin
                        mask_reg  <= mask_reg | (4'b0001 << acc_lane);
                        pdata_reg <= pdata_reg | ({24'h000000, acc_byte} << {acc_lane, 3'b000});
                    end
                    state_reg <= word_reg ? S_ACC1 : S_CAPT;
                end
                S_ACC1:
                begin
                    if (lo_ram_reg)
                    begin
                        lo_reg <= mem_rdata;
                    end
                    hi_ram_reg <= !acc_port;
                    hi_reg     <= port_byte;
                    if (write_reg && acc_port)
                    begin
                        mask_reg  <= mask_reg | (4'b0001 << acc_lane);
                        pdata_reg <= pdata_reg | ({24'h000000, acc_byte} << {acc_lane, 3'b000});
                    end
                    state_reg <= S_CAPT;
                end
                S_CAPT:
                begin
                    if (!read_reg)
                    begin
                        rd_reg <= '0;
                    end
                    else if (word_reg)
                    begin
                        rd_reg <= {hi_ram_reg ? mem_rdata : hi_reg, lo_reg};
                    end
                    else
                    begin
                        rd_reg <= {8'h00, lo_ram_reg ? mem_rdata : lo_reg};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign read_data         = rd_reg;
    assign effective_address = ea_reg;
    assign stack_pointer_out = sp_reg;
    assign port_write_mask   = mask_reg;
    assign port_write_data   = pdata_reg;

endmodule

// ----- sim/addressing_mode_memory_unit_top_test.sv -----
module addressing_mode_memory_unit_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import amu_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1350;
    localparam int SETTLE       = 8;

    localparam logic [2:0] OP_SPARE_LO   = 3'd5;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;
    localparam logic [3:0] MODE_SPARE_LO = 4'd13;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  mode;
        logic        word;
        addr_t       opnd;
        logic [15:0] val;
        byte_t       x;
        byte_t       y;
        logic        page1;
        byte_t       sp;
        logic [31:0] ports;
    } mem_item_t;

    typedef struct packed {
        logic [15:0] rd;
        addr_t       ea;
        byte_t       sp;
        logic [3:0]  mask;
        logic [31:0] pdata;
    } mem_result_t;

    typedef struct packed {
        mem_item_t   item;
        logic        fixed;
        mem_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic [2:0]  operation       = '0;
    logic [3:0]  address_mode    = '0;
    logic        access_word     = 1'b0;
    addr_t       operand_address = '0;
    logic [15:0] write_value     = '0;
    byte_t       index_x         = '0;
    byte_t       index_y         = '0;
    logic        page_one_select = 1'b0;
    byte_t       stack_pointer_in = '0;
    logic [31:0] port_values     = '0;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    addr_t       effective_address;
    byte_t       stack_pointer_out;
    logic [3:0]  port_write_mask;
    logic [31:0] port_write_data;

    byte_t       ram_image [0:65535];
    bit          ram_known [0:65535];
    bit          hole_seen;
    addr_t       hole_addr;

    mem_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    bit          idle_on = 1'b1;
    bit          drained = 1'b0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          items_issued = 0;
    int          fill_loads = 0;
    int          cycle_count = 0;

    addressing_mode_memory_unit_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .address_mode      (address_mode),
        .access_word       (access_word),
        .operand_address   (operand_address),
        .write_value       (write_value),
        .index_x           (index_x),
        .index_y           (index_y),
        .page_one_select   (page_one_select),
        .stack_pointer_in  (stack_pointer_in),
        .port_values       (port_values),
        .done              (done),
        .read_data         (read_data),
        .effective_address (effective_address),
        .stack_pointer_out (stack_pointer_out),
        .port_write_mask   (port_write_mask),
        .port_write_data   (port_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_port(addr_t a);
        return (a >= PORT_FIRST) && (a <= PORT_LAST);
    endfunction

    function automatic byte_t ram_fetch(addr_t a);
        if (!ram_known[a] && !hole_seen)
        begin
            hole_seen = 1'b1;
            hole_addr = a;
        end
        return ram_known[a] ? ram_image[a] : 8'h00;
    endfunction

    function automatic void ram_store(addr_t a, byte_t v);
        ram_image[a] = v;
        ram_known[a] = 1'b1;
    endfunction

    function automatic addr_t pointer_at(addr_t a);
        byte_t lo;
        byte_t hi;
        lo = ram_fetch(a);
        hi = ram_fetch(a + 16'd1);
        return {hi, lo};
    endfunction

    function automatic byte_t bus_read(addr_t a, logic [31:0] ports);
        if (is_port(a))
            return ports[{a[1:0], 3'b000} +: 8];
        return ram_fetch(a);
    endfunction

    function automatic addr_t eff_addr(mem_item_t it);
        addr_t base;
        addr_t ea;
        byte_t off;
        base = it.page1 ? PAGE_ONE : 16'h0000;
        case (it.mode)
            MODE_DP:
            begin
                ea = base | {8'h00, it.opnd[7:0]};
            end
            MODE_DP_X:
            begin
                off = it.opnd[7:0] + it.x;
                ea  = base | {8'h00, off};
            end
            MODE_DP_Y:
            begin
                off = it.opnd[7:0] + it.y;
                ea  = base | {8'h00, off};
            end
            MODE_DP_IND:
            begin
                ea = pointer_at(base | {8'h00, it.opnd[7:0]});
            end
            MODE_ABS:
            begin
                ea = it.opnd;
            end
            MODE_X_IND:
            begin
                ea = base | {8'h00, it.x};
            end
            MODE_ABS_X:
            begin
                ea = it.opnd + {8'h00, it.x};
            end
            MODE_ABS_Y:
            begin
                ea = it.opnd + {8'h00, it.y};
            end
            MODE_DPX_IND:
            begin
                off = it.opnd[7:0] + it.x;
                ea  = pointer_at(base | {8'h00, off});
            end
            MODE_DPIND_Y:
            begin
                ea = pointer_at(base | {8'h00, it.opnd[7:0]}) + {8'h00, it.y};
            end
            MODE_ABSX_IND:
            begin
                ea = pointer_at(it.opnd + {8'h00, it.x});
            end
            MODE_Y_IND:
            begin
                ea = base | {8'h00, it.y};
            end
            default:
            begin
                ea = it.opnd;
            end
        endcase
        return ea;
    endfunction

    // commit low: walk the reads only, to find RAM bytes not yet written
    function automatic mem_result_t predict_access(mem_item_t it, bit commit);
        mem_result_t r;
        logic [15:0] rd;
        logic [3:0]  mask;
        logic [31:0] pdata;
        addr_t       ea;
        addr_t       a;
        byte_t       sp;
        byte_t       v;
        rd    = '0;
        mask  = '0;
        pdata = '0;
        ea    = '0;
        sp    = it.sp;
        case (it.op)
            OP_READ:
            begin
                ea       = eff_addr(it);
                rd[7:0]  = bus_read(ea, it.ports);
                if (it.word)
                    rd[15:8] = bus_read(ea + 16'd1, it.ports);
            end
            OP_WRITE:
            begin
                ea = eff_addr(it);
                for (int k = 0; k < (it.word ? 2 : 1); k++)
                begin
                    a = ea + 16'(k);
                    v = (k == 0) ? it.val[7:0] : it.val[15:8];
                    if (is_port(a))
                    begin
                        mask[a[1:0]]                  = 1'b1;
                        pdata[{a[1:0], 3'b000} +: 8] = v;
                    end
                    else if (a < PROTECT_BASE && commit)
                    begin
                        ram_store(a, v);
                    end
                end
            end
            OP_PUSH:
            begin
                ea = PAGE_ONE | {8'h00, it.sp};
                sp = it.sp - 8'd1;
                if (commit)
                    ram_store(ea, it.val[7:0]);
            end
            OP_POP:
            begin
                sp      = it.sp + 8'd1;
                ea      = PAGE_ONE | {8'h00, sp};
                rd[7:0] = bus_read(ea, it.ports);
            end
            OP_LOAD:
            begin
                ea = it.opnd;
                if (commit)
                    ram_store(ea, it.val[7:0]);
            end
            default:
            begin
            end
        endcase
        r.rd    = rd;
        r.ea    = ea;
        r.sp    = sp;
        r.mask  = mask;
        r.pdata = pdata;
        return r;
    endfunction

    function automatic mem_item_t mk(logic [2:0] op, logic [3:0] mode, logic word,
                                     addr_t opnd, logic [15:0] val, byte_t x, byte_t y,
                                     logic page1, byte_t sp, logic [31:0] ports);
        mem_item_t it;
        it.op    = op;
        it.mode  = mode;
        it.word  = word;
        it.opnd  = opnd;
        it.val   = val;
        it.x     = x;
        it.y     = y;
        it.page1 = page1;
        it.sp    = sp;
        it.ports = ports;
        return it;
    endfunction

    function automatic mem_result_t res(logic [15:0] rd, addr_t ea, byte_t sp,
                                        logic [3:0] mask, logic [31:0] pdata);
        mem_result_t r;
        r.rd    = rd;
        r.ea    = ea;
        r.sp    = sp;
        r.mask  = mask;
        r.pdata = pdata;
        return r;
    endfunction

    function automatic stim_row_t typed_row(mem_item_t it, mem_result_t want);
        stim_row_t row;
        row.item  = it;
        row.fixed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t model_row(mem_item_t it);
        stim_row_t row;
        row.item  = it;
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic addr_t pick_address();
        int unsigned sel;
        addr_t       a;
        sel = $urandom_range(99);
        if (sel < 25)
            a = 16'h00F0 | 16'($urandom_range(15));
        else if (sel < 40)
            a = {8'h01, 8'($urandom)};
        else if (sel < 55)
            a = 16'hFFB0 + 16'($urandom_range(79));
        else if (sel < 65)
            a = 16'($urandom_range(15));
        else
            a = 16'($urandom);
        return a;
    endfunction

    function automatic byte_t pick_index();
        int unsigned sel;
        byte_t       v;
        sel = $urandom_range(99);
        if (sel < 15)
            v = 8'h00;
        else if (sel < 30)
            v = 8'hFF;
        else if (sel < 45)
            v = 8'hF0 | 8'($urandom_range(15));
        else
            v = 8'($urandom);
        return v;
    endfunction

    // bias filler bytes so pointers sometimes land on the ports or wrap
    function automatic byte_t pick_fill();
        int unsigned sel;
        byte_t       v;
        sel = $urandom_range(99);
        if (sel < 20)
            v = 8'hF4 + 8'($urandom_range(3));
        else if (sel < 35)
            v = 8'h00;
        else if (sel < 45)
            v = 8'hFF;
        else
            v = 8'($urandom);
        return v;
    endfunction

    function automatic mem_item_t random_access();
        mem_item_t   it;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 35)
            it.op = OP_READ;
        else if (sel < 65)
            it.op = OP_WRITE;
        else if (sel < 75)
            it.op = OP_PUSH;
        else if (sel < 85)
            it.op = OP_POP;
        else if (sel < 95)
            it.op = OP_LOAD;
        else
            it.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        if ($urandom_range(99) < 8)
            it.mode = 4'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        else
            it.mode = 4'($urandom_range(MODE_Y_IND, MODE_NONE));
        it.word  = 1'($urandom_range(1));
        it.opnd  = pick_address();
        it.val   = 16'($urandom);
        it.x     = pick_index();
        it.y     = pick_index();
        it.page1 = 1'($urandom_range(1));
        it.sp    = pick_index();
        it.ports = $urandom;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            $display("mismatch in %s of result %0d: got %h, want %h",
                     name, results_checked, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        mem_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", 32'(read_data), 32'(want.rd));
                check_field("effective_address", 32'(effective_address), 32'(want.ea));
                check_field("stack_pointer_out", 32'(stack_pointer_out), 32'(want.sp));
                check_field("port_write_mask", 32'(port_write_mask), 32'(want.mask));
                check_field("port_write_data", port_write_data, want.pdata);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("addressing_mode_memory_unit_top test failed");
            $finish;
        end
    end

    // hold the item until the edge that accepts it
    task automatic present_item(input mem_item_t it, input mem_result_t want);
        while (idle_on && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        operation        <= it.op;
        address_mode     <= it.mode;
        access_word      <= it.word;
        operand_address  <= it.opnd;
        write_value      <= it.val;
        index_x          <= it.x;
        index_y          <= it.y;
        page_one_select  <= it.page1;
        stack_pointer_in <= it.sp;
        port_values      <= it.ports;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(want);
        items_issued++;
    endtask

    // load every RAM byte the item would read before it is sent
    task automatic issue_item(input mem_item_t it, input bit fixed, input mem_result_t want);
        mem_item_t   fill;
        mem_result_t r;
        hole_seen = 1'b0;
        r = predict_access(it, 1'b0);
        while (hole_seen)
        begin
            fill      = random_access();
            fill.op   = OP_LOAD;
            fill.opnd = hole_addr;
            fill.val  = {8'($urandom), pick_fill()};
            present_item(fill, predict_access(fill, 1'b1));
            fill_loads++;
            hole_seen = 1'b0;
            r = predict_access(it, 1'b0);
        end
        r = predict_access(it, 1'b1);
        present_item(it, fixed ? want : r);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        directed_rows.push_back(typed_row(
            mk(OP_LOAD, MODE_NONE, 1'b0, 16'h0100, 16'h005A, 8'h00, 8'h00, 1'b0, 8'h10, 32'h0),
            res(16'h0000, 16'h0100, 8'h10, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_POP, MODE_NONE, 1'b0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 8'hFF, 32'h0),
            res(16'h005A, 16'h0100, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_PUSH, MODE_NONE, 1'b0, 16'h0000, 16'hFFA5, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'h0100, 8'hFF, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_READ, MODE_NONE, 1'b0, 16'h0100, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h33, 32'h0),
            res(16'h00A5, 16'h0100, 8'h33, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_WRITE, MODE_ABS, 1'b1, 16'h00F7, 16'hBEEF, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'h00F7, 8'h00, 4'b1000, 32'hEF00_0000)));
        directed_rows.push_back(typed_row(
            mk(OP_READ, MODE_DP, 1'b1, 16'hABF4, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00,
               32'h4433_2211),
            res(16'h2211, 16'h00F4, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_LOAD, MODE_NONE, 1'b0, 16'hFFC0, 16'h0011, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'hFFC0, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_WRITE, MODE_ABS, 1'b0, 16'hFFC0, 16'h0099, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'hFFC0, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_READ, MODE_ABS, 1'b0, 16'hFFC0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0011, 16'hFFC0, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_LOAD, MODE_NONE, 1'b0, 16'hFFFF, 16'h0022, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'hFFFF, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_LOAD, MODE_NONE, 1'b0, 16'h0000, 16'h0033, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h0000, 16'h0000, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_READ, MODE_NONE, 1'b1, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 32'h0),
            res(16'h3322, 16'hFFFF, 8'h00, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_SPARE_HI, MODE_ABS, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h42,
               32'hFFFF_FFFF),
            res(16'h0000, 16'h0000, 8'h42, 4'h0, 32'h0)));
        directed_rows.push_back(typed_row(
            mk(OP_SPARE_LO, MODE_NONE, 1'b0, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 8'hFF, 32'h0),
            res(16'h0000, 16'h0000, 8'hFF, 4'h0, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_WRITE, MODE_DP_X, 1'b1, 16'h00F0, 16'hFFFF, 8'h20, 8'h00, 1'b1, 8'h00, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_DP_Y, 1'b1, 16'h00FF, 16'h0000, 8'h00, 8'hFF, 1'b1, 8'h00, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_DP_IND, 1'b0, 16'h00FF, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_X_IND, 1'b1, 16'h0000, 16'h0000, 8'hF5, 8'h00, 1'b0, 8'h00,
               32'hA1B2_C3D4)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_ABS_X, 1'b0, 16'hFFFF, 16'h0000, 8'hFF, 8'h00, 1'b0, 8'h00, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_ABS_Y, 1'b1, 16'hFFF0, 16'h0000, 8'h00, 8'h20, 1'b0, 8'h00, 32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_DPX_IND, 1'b1, 16'h00FF, 16'h0000, 8'h01, 8'h00, 1'b0, 8'h00,
               32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_WRITE, MODE_DPIND_Y, 1'b0, 16'h0010, 16'h1234, 8'h00, 8'hFF, 1'b0, 8'h00,
               32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_ABSX_IND, 1'b1, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00,
               32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_WRITE, MODE_Y_IND, 1'b1, 16'h0000, 16'hC3A5, 8'h00, 8'hF6, 1'b0, 8'h00,
               32'h0)));
        directed_rows.push_back(model_row(
            mk(OP_READ, MODE_SPARE_LO, 1'b1, 16'h00F4, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00,
               32'hFFFF_FFFF)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
        wait_for_results();

        while (items_issued < ITEM_TARGET)
        begin
            idle_on = !(items_issued >= 500 && items_issued < 800);
            if (!drained && items_issued >= 1000)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            issue_item(random_access(), 1'b0, '0);
        end

        wait_for_results();
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d items (%0d directed rows, %0d RAM fill loads), %0d results checked",
                 items_issued, directed_rows.size(), fill_loads, results_checked);
        $display("all thirteen modes, spare modes and ops, ports, stack wrap and protected top");
        if (mismatches == 0)
            $display("addressing_mode_memory_unit_top test passed");
        else
            $display("addressing_mode_memory_unit_top test failed");
        $finish;
    end

endmodule
